// ===== design/pdau_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the polarization unit.
// No dependencies; imported by every module of the block except pdau_delay.
`default_nettype none

package pdau_pkg;

  localparam int SAMPLE_BITS_DEF = 8;

  // result field widths, lowest field of m_axis_tdata first
  localparam int MEAN_W = 10;
  localparam int MAXI_W = 11;
  localparam int MINI_W = 11;
  localparam int DOLP_W = 16;
  localparam int AOLP_W = 16;
  localparam int OUT_W  = MEAN_W + MAXI_W + MINI_W + DOLP_W + AOLP_W;

  // sqrt(S * 2^30) carries 15 fraction bits; amplitude keeps 14 fewer
  localparam int SQRT_SHIFT = 30;
  localparam int AMP_SHIFT  = 14;

  localparam int DIV_STEPS = 16;
  localparam logic [DOLP_W-1:0] DOLP_ONE = 16'd32768;

  // CORDIC: angle in 2^-32 turn, vector scaled by 2^40
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_FRAC  = 40;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int ANG_W        = 34;
  localparam int TURN_W       = 30;
  localparam int ANG_RND      = 65536;
  localparam int ANG_OUT_SH   = 17;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sd1073741824;
  localparam logic [AOLP_W-1:0] AOLP_HALF = 16'd16384;
  localparam logic [AOLP_W-1:0] AOLP_PI   = 16'd32768;

  typedef struct packed {
    logic c2_zero;
    logic c2_pos;
    logic c1_neg;
  } pdau_aflags_t;

  function automatic logic [TURN_W-1:0] cordic_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] t;
    unique case (idx)
      5'd0:  t = 30'd536870912;
      5'd1:  t = 30'd316933406;
      5'd2:  t = 30'd167458907;
      5'd3:  t = 30'd85004756;
      5'd4:  t = 30'd42667331;
      5'd5:  t = 30'd21354465;
      5'd6:  t = 30'd10679838;
      5'd7:  t = 30'd5340245;
      5'd8:  t = 30'd2670163;
      5'd9:  t = 30'd1335087;
      5'd10: t = 30'd667544;
      5'd11: t = 30'd333772;
      5'd12: t = 30'd166886;
      5'd13: t = 30'd83443;
      5'd14: t = 30'd41722;
      5'd15: t = 30'd20861;
      5'd16: t = 30'd10430;
      5'd17: t = 30'd5215;
      5'd18: t = 30'd2608;
      5'd19: t = 30'd1304;
      5'd20: t = 30'd652;
      5'd21: t = 30'd326;
      5'd22: t = 30'd163;
      5'd23: t = 30'd81;
      5'd24: t = 30'd41;
      5'd25: t = 30'd20;
      5'd26: t = 30'd10;
      5'd27: t = 30'd5;
      5'd28: t = 30'd3;
      5'd29: t = 30'd1;
      5'd30: t = 30'd1;
      5'd31: t = 30'd0;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== design/pdau_delay.sv =====
// Enable-gated shift line that keeps side data aligned with the long paths.
// No package dependencies.
`default_nettype none

module pdau_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/pdau_sqrt.sv =====
// Pipelined digit-by-digit square root of (s_i << SQRT_SHIFT), one root bit per stage.
// Depends on pdau_pkg.
`default_nettype none

module pdau_sqrt #(
  parameter int IN_W   = 17,
  parameter int ROOT_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [IN_W-1:0]   s_i,
  output logic      [ROOT_W-1:0] root_o
);
  import pdau_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  logic [RAD_W-1:0] rad_in;
  assign rad_in = RAD_W'({s_i, {SQRT_SHIFT{1'b0}}});

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int HI = RAD_W - 1 - 2 * k;
    logic [RAD_W-1:0]  rad_s;
    logic [REM_W-1:0]  rem_s, rem_n, trial, rem_d;
    logic [ROOT_W-1:0] root_s, root_d;

    if (k == 0) begin : g_first
      assign rad_s  = rad_in;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
    end

    always_comb begin
      rem_n = {rem_s[REM_W-3:0], rad_s[HI -: 2]};
      trial = {1'b0, root_s, 2'b01};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_s[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_s[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_s;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/pdau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the DoLP ratio.
// Depends on pdau_pkg.
`default_nettype none

module pdau_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 11
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [NUM_W-1:0]               num_i,
  input  wire logic [DEN_W-1:0]               den_i,
  output logic      [pdau_pkg::DIV_STEPS-1:0] quo_o
);
  import pdau_pkg::*;

  localparam int CMP_W = ((NUM_W > DEN_W + DIV_STEPS) ? NUM_W : DEN_W + DIV_STEPS) + 1;

  logic [NUM_W-1:0]     rem_q [DIV_STEPS];
  logic [DEN_W-1:0]     den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0]     rem_s, rem_d;
    logic [DEN_W-1:0]     den_s;
    logic [DIV_STEPS-1:0] quo_s, quo_d;
    logic [CMP_W-1:0]     rem_x, den_x;

    if (k == 0) begin : g_first
      assign rem_s = num_i;
      assign den_s = den_i;
      assign quo_s = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign den_s = den_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    always_comb begin
      rem_x = CMP_W'(rem_s);
      den_x = CMP_W'(den_s) << BIT;
      rem_d = rem_s;
      quo_d = quo_s;
      if (rem_x >= den_x) begin
        rem_d      = NUM_W'(rem_x - den_x);
        quo_d[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_s;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== design/pdau_cordic.sv =====
// Pipelined vectoring CORDIC giving the AoLP code from (c1, c2).
// Depends on pdau_pkg (angle table, flags struct, constants).
`default_nettype none

module pdau_cordic #(
  parameter int C_W = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic signed [C_W-1:0]       c1_i,
  input  wire logic signed [C_W-1:0]       c2_i,
  output logic        [pdau_pkg::AOLP_W-1:0] aolp_o
);
  import pdau_pkg::*;

  localparam int XW = C_W + CORDIC_FRAC + 3;

  logic signed [XW-1:0]    x_q   [CORDIC_STEPS+1];
  logic signed [XW-1:0]    y_q   [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ang_q [CORDIC_STEPS+1];
  pdau_aflags_t            flg_q [CORDIC_STEPS+1];
  logic [AOLP_W-1:0]       aolp_q;

  // pre-rotation into the right half plane
  logic signed [C_W:0]     xe, ye, x0, y0;
  logic signed [ANG_W-1:0] a0;
  pdau_aflags_t            f0;

  always_comb begin
    xe = (C_W+1)'(c1_i);
    ye = (C_W+1)'(c2_i);
    x0 = xe;
    y0 = ye;
    a0 = '0;
    if (c1_i < 0) begin
      if (c2_i >= 0) begin
        x0 = ye;
        y0 = -xe;
        a0 = ANG_QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        a0 = -ANG_QUARTER;
      end
    end
    f0.c2_zero = (c2_i == 0);
    f0.c2_pos  = (c2_i > 0);
    f0.c1_neg  = (c1_i < 0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= XW'(x0) <<< CORDIC_FRAC;
      y_q[0]   <= XW'(y0) <<< CORDIC_FRAC;
      ang_q[0] <= a0;
      flg_q[0] <= f0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic signed [XW-1:0]    dx, dy;
    logic signed [ANG_W-1:0] turn;

    assign dx   = x_q[k] >>> k;
    assign dy   = y_q[k] >>> k;
    assign turn = $signed({{(ANG_W-TURN_W){1'b0}}, cordic_turn(5'(k))});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k] > 0) begin
          x_q[k+1]   <= x_q[k] + dy;
          y_q[k+1]   <= y_q[k] - dx;
          ang_q[k+1] <= ang_q[k] + turn;
        end else begin
          x_q[k+1]   <= x_q[k] - dy;
          y_q[k+1]   <= y_q[k] + dx;
          ang_q[k+1] <= ang_q[k] - turn;
        end
        flg_q[k+1] <= flg_q[k];
      end
    end
  end

  // halve the angle with rounding, then fold into (0, pi]
  logic signed [ANG_W:0] ang_r;
  logic [AOLP_W-1:0]     q16, aolp_d;
  pdau_aflags_t          fl;

  always_comb begin
    fl     = flg_q[CORDIC_STEPS];
    ang_r  = (ANG_W+1)'(ang_q[CORDIC_STEPS]) + (ANG_W+1)'(ANG_RND);
    q16    = ang_r[ANG_OUT_SH +: AOLP_W];
    if (!fl.c2_pos) begin
      q16 = q16 + AOLP_PI;
    end
    aolp_d = q16;
    if (fl.c2_zero) begin
      aolp_d = fl.c1_neg ? AOLP_HALF : AOLP_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aolp_q <= aolp_d;
    end
  end

  assign aolp_o = aolp_q;

endmodule

`default_nettype wire

// ===== design/polarization_dolp_aolp_unit.sv =====
// Linear polarization of one 2x2 superpixel: mean, max/min intensity, DoLP and AoLP.
// Depends on pdau_pkg, pdau_delay, pdau_sqrt, pdau_div and pdau_cordic.
//
// Takes one superpixel per clock while s_axis_tready is high and returns one result
// per superpixel, in order. The bit-serial square root (one stage per root bit,
// SAMPLE_BITS + 16 stages) followed by the 16-stage DoLP divider sets the depth;
// the 34-stage CORDIC runs beside it. Throughput is one item per cycle while the
// pipeline is not frozen. A two-entry output buffer lets s_axis_tready stay high
// while one result waits; the pipeline freezes only when both entries hold results.
`default_nettype none

module polarization_dolp_aolp_unit #(
  parameter int SAMPLE_BITS = pdau_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // sample_0deg, sample_45deg, sample_90deg, sample_135deg (low bits first)
  input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // mean_intensity, max_intensity, min_intensity, dolp, aolp (low bits first)
  output logic [pdau_pkg::OUT_W-1:0] m_axis_tdata
);
  import pdau_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int C_W      = SB + 1;
  localparam int SUM_W    = SB + 2;
  localparam int SQ_W     = 2 * SB + 1;
  localparam int ROOT_W   = (SQ_W + SQRT_SHIFT + 1) / 2;
  localparam int AMP_W    = ROOT_W + 1 - AMP_SHIFT;
  localparam int NUM_W    = ROOT_W + 2;
  localparam int DEN_W    = SUM_W + 1;
  localparam int PIPE_LEN = ROOT_W + 4 + DIV_STEPS;
  localparam int AOLP_DLY = PIPE_LEN - 1 - CORDIC_LAT;
  localparam int RES_W    = SB + 4;

  logic en;
  logic [PIPE_LEN-1:0] vld_q;
  logic ov_q, sv_q;

  assign en            = ~sv_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], s_axis_tvalid};
    end
  end

  // stage a: differences and sum
  logic [SB-1:0] s0, s45, s90, s135;
  assign s0   = s_axis_tdata[0*SB +: SB];
  assign s45  = s_axis_tdata[1*SB +: SB];
  assign s90  = s_axis_tdata[2*SB +: SB];
  assign s135 = s_axis_tdata[3*SB +: SB];

  logic signed [C_W-1:0] c1_q, c2_q;
  logic [SUM_W-1:0]      sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= $signed({1'b0, s0}) - $signed({1'b0, s90});
      c2_q  <= $signed({1'b0, s45}) - $signed({1'b0, s135});
      sum_q <= SUM_W'(s0) + SUM_W'(s45) + SUM_W'(s90) + SUM_W'(s135);
    end
  end

  // stage b: squares, stage c: S = c1^2 + c2^2
  logic signed [2*C_W-1:0] p1, p2;
  logic [2*SB-1:0]         sq1_q, sq2_q;
  logic [SQ_W-1:0]         s_q;

  assign p1 = c1_q * c1_q;
  assign p2 = c2_q * c2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q <= p1[2*SB-1:0];
      sq2_q <= p2[2*SB-1:0];
      s_q   <= SQ_W'(sq1_q) + SQ_W'(sq2_q);
    end
  end

  logic [ROOT_W-1:0] rr;

  pdau_sqrt #(
    .IN_W   (SQ_W),
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s_q),
    .root_o (rr)
  );

  logic [SUM_W-1:0] sum_r;

  pdau_delay #(
    .WIDTH (SUM_W),
    .DEPTH (ROOT_W + 2)
  ) u_dly_sum (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (sum_q),
    .q_o   (sum_r)
  );

  // prep stage: rounded amplitude and divider operands
  logic [ROOT_W:0]  rr_rnd;
  logic [AMP_W-1:0] amp_q;
  logic [SUM_W-1:0] sum_p_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  assign rr_rnd = {1'b0, rr} + (ROOT_W+1)'(1 << (AMP_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      amp_q   <= rr_rnd[ROOT_W:AMP_SHIFT];
      sum_p_q <= sum_r;
      num_q   <= {1'b0, rr, 1'b0} + NUM_W'(sum_r);
      den_q   <= {sum_r, 1'b0};
    end
  end

  logic [DIV_STEPS-1:0] quo;

  pdau_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  logic [SUM_W-1:0] sum_e;
  logic [AMP_W-1:0] amp_e;

  pdau_delay #(
    .WIDTH (SUM_W + AMP_W),
    .DEPTH (DIV_STEPS)
  ) u_dly_amp (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({sum_p_q, amp_q}),
    .q_o   ({sum_e, amp_e})
  );

  logic [AOLP_W-1:0] aolp_c, aolp_e;

  pdau_cordic #(
    .C_W (C_W)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .c1_i   (c1_q),
    .c2_i   (c2_q),
    .aolp_o (aolp_c)
  );

  pdau_delay #(
    .WIDTH (AOLP_W),
    .DEPTH (AOLP_DLY)
  ) u_dly_aolp (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (aolp_c),
    .q_o   (aolp_e)
  );

  // result assembly
  logic [RES_W-1:0]  mx, mn;
  logic [DOLP_W-1:0] dolp;
  logic [OUT_W-1:0]  res;

  always_comb begin
    mx   = RES_W'(sum_e) + RES_W'(amp_e);
    mn   = RES_W'(sum_e) - RES_W'(amp_e);
    dolp = (quo > DOLP_ONE) ? DOLP_ONE : quo;
    if (sum_e == '0) begin
      dolp = '0;
    end
    res = {aolp_e, dolp, mn[MINI_W-1:0], mx[MAXI_W-1:0], sum_e[MEAN_W-1:0]};
  end

  // output register plus skid entry
  logic [OUT_W-1:0] out_q, skid_q;
  logic             last_v;

  assign last_v = vld_q[PIPE_LEN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (m_axis_tready) begin
        sv_q <= 1'b0;
      end
    end else if (last_v) begin
      if (ov_q && !m_axis_tready) begin
        sv_q <= 1'b1;
      end else begin
        ov_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (last_v) begin
      if (ov_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  localparam int DOLP_LSB = MEAN_W + MAXI_W + MINI_W;
  localparam int AOLP_LSB = DOLP_LSB + DOLP_W;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid entry full while output register empty");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q && m_axis_tready |=> m_axis_tvalid)
    else $error("skid item lost on drain");

  a_dolp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DOLP_LSB +: DOLP_W] <= DOLP_ONE)
    else $error("dolp above one");

  a_aolp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[AOLP_LSB +: AOLP_W] <= AOLP_PI)
    else $error("aolp above pi");

endmodule

`default_nettype wire

// ===== verif/tb_polarization_dolp_aolp_unit.sv =====
// Testbench for polarization_dolp_aolp_unit: drives superpixels on the input stream,
// predicts mean, max/min, DoLP and AoLP per item and checks every output item in order.
// Depends on pdau_pkg and the RTL of the unit.
`default_nettype none

module tb_polarization_dolp_aolp_unit;
  import pdau_pkg::*;

  localparam int SB = 8;
  localparam int IN_W = ((4*SB+7)/8)*8;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [AOLP_W-1:0] aolp;
    logic [DOLP_W-1:0] dolp;
    logic [MINI_W-1:0] min_i;
    logic [MAXI_W-1:0] max_i;
    logic [MEAN_W-1:0] mean_i;
  } pol_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  pol_result_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;  // no idling on either side while set

  polarization_dolp_aolp_unit #(.SAMPLE_BITS(SB)) dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_polarization_dolp_aolp_unit NOT OK");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int sh);
    return v >>> sh;  // arithmetic shift is floor division
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // atan2 in 2^-32 turn
  function automatic longint angle_turns(longint y, longint x);
    longint ang = 0, t, dx, dy;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 1073741824;
      end else begin
        t = x; x = -y; y = t; ang = -1073741824;
      end
    end
    x = x * (64'sd1 <<< CORDIC_FRAC);
    y = y * (64'sd1 <<< CORDIC_FRAC);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(cordic_turn(5'(i)));
      end else begin
        x -= dx; y += dy; ang -= longint'(cordic_turn(5'(i)));
      end
    end
    return ang;
  endfunction

  function automatic pol_result_t predict_polarization(logic [SB-1:0] s0, logic [SB-1:0] s45,
                                                      logic [SB-1:0] s90, logic [SB-1:0] s135);
    pol_result_t r;
    longint c1, c2, sum, amp, q;
    longint unsigned sq, rt, d, a;
    c1 = longint'(s0) - longint'(s90);
    c2 = longint'(s45) - longint'(s135);
    sum = longint'(s0) + s45 + s90 + s135;
    sq = c1 * c1 + c2 * c2;
    rt = int_sqrt(4 * sq);
    if (4 * sq - rt * rt > rt) rt++;
    amp = longint'(rt);
    if (sum == 0) begin
      d = 0;
    end else begin
      d = (2 * int_sqrt(sq << SQRT_SHIFT) + sum) / (2 * sum);
      if (d > 32768) d = 32768;
    end
    if (c2 == 0) begin
      a = (c1 < 0) ? 16384 : 32768;
    end else begin
      q = floor_shr(angle_turns(c2, c1) + ANG_RND, ANG_OUT_SH);
      if (c2 < 0) q += 32768;
      a = longint'(q);
    end
    r.mean_i = MEAN_W'(sum);
    r.max_i = MAXI_W'(sum + amp);
    r.min_i = MINI_W'(sum - amp);
    r.dolp = DOLP_W'(d);
    r.aolp = AOLP_W'(a);
    return r;
  endfunction

  // tvalid stays up after an accept; the next send or an idle cycle sets it
  task automatic send_superpixel(logic [SB-1:0] s0, logic [SB-1:0] s45,
                                 logic [SB-1:0] s90, logic [SB-1:0] s135);
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s135, s90, s45, s0};
    pending_results.push_back(predict_polarization(s0, s45, s90, s135));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker with random receiver stalls
  always @(posedge clk_i) begin
    pol_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_results.size() == 0) begin
          $error("output item with no expected result");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.mean_i !== want.mean_i) begin
            $error("mean_intensity exp %0d got %0d", want.mean_i, got.mean_i); errors++;
          end
          if (got.max_i !== want.max_i) begin
            $error("max_intensity exp %0d got %0d", want.max_i, got.max_i); errors++;
          end
          if (got.min_i !== want.min_i) begin
            $error("min_intensity exp %0d got %0d", $signed(want.min_i), $signed(got.min_i));
            errors++;
          end
          if (got.dolp !== want.dolp) begin
            $error("dolp exp %0d got %0d", want.dolp, got.dolp); errors++;
          end
          if (got.aolp !== want.aolp) begin
            $error("aolp exp %0d got %0d", want.aolp, got.aolp); errors++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  task automatic test_extremes();
    send_superpixel(0, 0, 0, 0);        // zero mean, zero vector
    send_superpixel(255, 255, 255, 255);
    send_superpixel(255, 0, 0, 0);      // c2 zero, c1 positive
    send_superpixel(0, 0, 255, 0);      // c2 zero, c1 negative
    send_superpixel(0, 255, 0, 0);
    send_superpixel(0, 0, 0, 255);
    send_superpixel(255, 255, 0, 0);
    send_superpixel(0, 0, 255, 255);
    send_superpixel(255, 0, 0, 255);    // min goes negative
    send_superpixel(0, 255, 255, 0);
    send_superpixel(255, 1, 0, 0);      // tiny positive angle
    send_superpixel(255, 0, 0, 1);      // tiny negative angle
    send_superpixel(0, 1, 255, 0);
    send_superpixel(0, 0, 255, 1);
    send_superpixel(8'haa, 8'h55, 8'haa, 8'h55);
    send_superpixel(8'h55, 8'haa, 8'h55, 8'haa);
    send_superpixel(1, 0, 0, 0);
    send_superpixel(128, 128, 128, 128);
  endtask

  task automatic test_random(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        // small differences around a random level
        automatic int b = $urandom_range(2, 253);
        send_superpixel(8'(b + $urandom_range(2) - 1), 8'(b + $urandom_range(2) - 1),
                        8'(b + $urandom_range(2) - 1), 8'(b + $urandom_range(2) - 1));
      end else if (mode == 1) begin
        send_superpixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(3)));
      end else begin
        send_superpixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      if (i == n / 2) wait_drained();  // let the pipeline empty once
    end
  endtask

  task automatic test_back_to_back(int n);
    calm = 1'b1;
    for (int i = 0; i < n; i++)
      send_superpixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(700);
    test_back_to_back(200);
    test_random(500);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_polarization_dolp_aolp_unit OK");
    end else begin
      $display("tb_polarization_dolp_aolp_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/pdau_pkg.sv
design/pdau_delay.sv
design/pdau_sqrt.sv
design/pdau_div.sv
design/pdau_cordic.sv
design/polarization_dolp_aolp_unit.sv
verif/tb_polarization_dolp_aolp_unit.sv
